### hw/rtl/clb_pkg.sv
// clb_pkg: command codes, status codes and the result record shared by the
// cursor list buffer top level, its sequencer and the testbench. No dependencies.
package clb_pkg;

    localparam logic [3:0] MODE_INSERT  = 4'd0;
    localparam logic [3:0] MODE_FRONT   = 4'd1;
    localparam logic [3:0] MODE_REAR    = 4'd2;
    localparam logic [3:0] MODE_NEXT    = 4'd3;
    localparam logic [3:0] MODE_PREV    = 4'd4;
    localparam logic [3:0] MODE_DELETE  = 4'd5;
    localparam logic [3:0] MODE_READ    = 4'd6;
    localparam logic [3:0] MODE_REPLACE = 4'd7;
    localparam logic [3:0] MODE_MOVE    = 4'd8;
    localparam logic [3:0] MODE_COUNT   = 4'd9;
    localparam logic [3:0] MODE_CLEAR   = 4'd10;
    localparam logic [3:0] MODE_EMPTY   = 4'd11;
    localparam logic [3:0] MODE_REVERSE = 4'd12;
    localparam logic [3:0] MODE_DUMP    = 4'd13;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // longest run of results a dump produces
    localparam int MAX_RES = 32;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] out_byte;
        logic [5:0] entry_count;
        logic [5:0] cursor_pos;
        logic       is_empty;
        logic       last_item;
    } res_t;

endpackage

### hw/rtl/cursor_list_buffer_unit.sv
// cursor_list_buffer_unit: top level of the cursor list buffer.
// Uses clb_pkg, clb_store and clb_seq.
//
//  port group  dir  handshake           payload
//  ----------  ---  ------------------  ------------------------------------------
//  request     in   in_valid/in_stall   mode, data_byte, target_position
//  result      out  out_valid/out_stall status, out_byte, entry_count, cursor_pos,
//                                       is_empty, last_item
//
// One request at a time. A simple command passes through decode and a response
// state before its result is registered; read adds a wait for the memory data.
// Insert, delete and move walk the shifted entries through the single-read,
// single-write entry memory at one entry per cycle. Reverse swaps each pair by
// reading both ends and then writing both ends; dump sends one entry each time
// the output register can take a result. in_stall is high from acceptance until
// the last result of the request has entered the output register. Reset clears
// count and cursor; the memory is not cleared and is only read below the fill
// count. out_stall holds a full output register and the sequencer at its results.
module cursor_list_buffer_unit
    import clb_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [3:0] mode,
    input  logic [7:0] data_byte,
    input  logic [4:0] target_position,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic [7:0] out_byte,
    output logic [5:0] entry_count,
    output logic [5:0] cursor_pos,
    output logic       is_empty,
    output logic       last_item
);

    // entry index and fill count widths
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic          cmd_ready;
    logic          res_valid;
    logic          res_free;
    res_t          res;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_ren;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    logic          out_valid_reg, out_valid_next;
    res_t          out_reg;

    assign in_stall = !cmd_ready;

    clb_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (in_valid),
        .cmd_ready  (cmd_ready),
        .cmd_mode   (mode),
        .cmd_data   (data_byte),
        .cmd_target (target_position),
        .res_valid  (res_valid),
        .res_free   (res_free),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_ren    (mem_ren),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    clb_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .ren   (mem_ren),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register: takes a result when empty or when its result leaves
    assign res_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_free)
            out_valid_next = res_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_free && res_valid)
            out_reg <= res;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign out_byte    = out_reg.out_byte;
    assign entry_count = out_reg.entry_count;
    assign cursor_pos  = out_reg.cursor_pos;
    assign is_empty    = out_reg.is_empty;
    assign last_item   = out_reg.last_item;

endmodule

### hw/rtl/clb_store.sv
// clb_store: entry memory, one write port and one registered read port.
// No package dependencies.
module clb_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          ren,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while ren is low
    always_ff @(posedge clk)
    begin
        if (ren)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/clb_seq.sv
// clb_seq: command sequencer. Steps shifts, swaps and dumps through the
// entry memory, overlapping reads and writes. Depends on clb_pkg.
module clb_seq
    import clb_pkg::*;
#(
    parameter int CAPACITY = 32,
    parameter int AW       = 5,
    parameter int CW       = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  logic [3:0]    cmd_mode,
    input  logic [7:0]    cmd_data,
    input  logic [4:0]    cmd_target,
    output logic          res_valid,
    input  logic          res_free,
    output res_t          res,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic [7:0]    mem_wdata,
    output logic          mem_ren,
    output logic [AW-1:0] mem_raddr,
    input  logic [7:0]    mem_rdata
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEC    = 4'd1;
    localparam logic [3:0] S_MVHOLD = 4'd2;
    localparam logic [3:0] S_SHIFT  = 4'd3;
    localparam logic [3:0] S_FIN    = 4'd4;
    localparam logic [3:0] S_RDWAIT = 4'd5;
    localparam logic [3:0] S_RV1    = 4'd6;
    localparam logic [3:0] S_RV2    = 4'd7;
    localparam logic [3:0] S_RV3    = 4'd8;
    localparam logic [3:0] S_DUMP   = 4'd9;
    localparam logic [3:0] S_RESP   = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic          rd_act_reg, rd_act_next;
    logic          wp_reg, wp_next;

    logic [3:0]    mode_reg, mode_next;
    logic [7:0]    data_reg, data_next;
    logic [4:0]    tgt_reg, tgt_next;
    logic [1:0]    status_reg, status_next;
    logic [7:0]    byte_reg, byte_next;
    logic [7:0]    hold_reg, hold_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] jdx_reg, jdx_next;
    logic [AW-1:0] last_reg, last_next;
    logic [AW-1:0] wa_reg, wa_next;
    logic [AW-1:0] fin_reg, fin_next;
    logic          up_reg, up_next;

    logic          empty;
    logic          full;
    logic [AW-1:0] ins_pos;
    logic [AW-1:0] fill_m1;
    logic [AW-1:0] tgt_a;
    logic          tgt_bad;
    logic          dump_end;
    logic [CW+5:0] fill_ext;
    logic [AW+5:0] cur_ext;

    assign empty   = (fill_reg == '0);
    assign full    = (fill_reg == CW'(CAPACITY));
    assign ins_pos = empty ? '0 : cur_reg + AW'(1);
    assign fill_m1 = AW'(fill_reg - CW'(1));
    assign tgt_a   = AW'(tgt_reg);
    assign tgt_bad = ({{CW{1'b0}}, tgt_reg} >= {5'd0, fill_reg});
    assign dump_end = (idx_reg == last_reg);

    assign cmd_ready = (state_reg == S_IDLE);

    // result record; count and cursor wrap to six bits
    assign fill_ext = {6'd0, fill_reg};
    assign cur_ext  = {6'd0, cur_reg};

    always_comb
    begin
        res.status      = (state_reg == S_DUMP) ? ST_OK : status_reg;
        res.out_byte    = (state_reg == S_DUMP) ? mem_rdata : byte_reg;
        res.entry_count = fill_ext[5:0];
        res.cursor_pos  = empty ? 6'h3F : cur_ext[5:0];
        res.is_empty    = empty;
        res.last_item   = (state_reg == S_DUMP) ? dump_end : 1'b1;
        res_valid       = (state_reg == S_RESP) || (state_reg == S_DUMP);
    end

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        cur_next    = cur_reg;
        rd_act_next = rd_act_reg;
        wp_next     = wp_reg;
        mode_next   = mode_reg;
        data_next   = data_reg;
        tgt_next    = tgt_reg;
        status_next = status_reg;
        byte_next   = byte_reg;
        hold_next   = hold_reg;
        idx_next    = idx_reg;
        jdx_next    = jdx_reg;
        last_next   = last_reg;
        wa_next     = wa_reg;
        fin_next    = fin_reg;
        up_next     = up_reg;
        mem_we      = 1'b0;
        mem_waddr   = wa_reg;
        mem_wdata   = mem_rdata;
        mem_ren     = 1'b0;
        mem_raddr   = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    mode_next  = cmd_mode;
                    data_next  = cmd_data;
                    tgt_next   = cmd_target;
                    state_next = S_DEC;
                end
            end

            S_DEC:
            begin
                status_next = ST_OK;
                byte_next   = 8'd0;
                state_next  = S_RESP;
                rd_act_next = 1'b1;
                wp_next     = 1'b0;
                unique case (mode_reg)
                    MODE_INSERT:
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            fin_next = ins_pos;
                            if (fill_reg > CW'(ins_pos))
                            begin
                                // open a gap: move fill-1 .. pos up by one
                                idx_next   = fill_m1;
                                last_next  = ins_pos;
                                up_next    = 1'b0;
                                state_next = S_SHIFT;
                            end
                            else
                            begin
                                state_next = S_FIN;
                            end
                        end
                    end
                    MODE_FRONT:
                    begin
                        if (empty)
                            status_next = ST_INVALID;
                        else
                            cur_next = '0;
                    end
                    MODE_REAR:
                    begin
                        if (empty)
                            status_next = ST_INVALID;
                        else
                            cur_next = fill_m1;
                    end
                    MODE_NEXT:
                    begin
                        if (!empty && (CW'(cur_reg) + CW'(1) < fill_reg))
                            cur_next = cur_reg + AW'(1);
                        else
                            status_next = ST_INVALID;
                    end
                    MODE_PREV:
                    begin
                        if (!empty && (cur_reg != '0))
                            cur_next = cur_reg - AW'(1);
                        else
                            status_next = ST_INVALID;
                    end
                    MODE_DELETE:
                    begin
                        if (empty)
                        begin
                            status_next = ST_INVALID;
                        end
                        else if (CW'(cur_reg) + CW'(1) < fill_reg)
                        begin
                            // close the gap: move cur+1 .. fill-1 down by one
                            idx_next   = cur_reg + AW'(1);
                            last_next  = fill_m1;
                            up_next    = 1'b1;
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            state_next = S_FIN;
                        end
                    end
                    MODE_READ:
                    begin
                        if (empty)
                        begin
                            status_next = ST_INVALID;
                        end
                        else
                        begin
                            mem_ren    = 1'b1;
                            mem_raddr  = cur_reg;
                            state_next = S_RDWAIT;
                        end
                    end
                    MODE_REPLACE:
                    begin
                        if (empty)
                        begin
                            status_next = ST_INVALID;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = cur_reg;
                            mem_wdata = data_reg;
                        end
                    end
                    MODE_MOVE:
                    begin
                        if (empty || tgt_bad)
                        begin
                            status_next = ST_INVALID;
                        end
                        else
                        begin
                            mem_ren    = 1'b1;
                            mem_raddr  = cur_reg;
                            state_next = S_MVHOLD;
                        end
                    end
                    MODE_COUNT, MODE_EMPTY:
                    begin
                    end
                    MODE_CLEAR:
                    begin
                        fill_next = '0;
                        cur_next  = '0;
                    end
                    MODE_REVERSE:
                    begin
                        if (fill_reg >= CW'(2))
                        begin
                            mem_ren    = 1'b1;
                            mem_raddr  = '0;
                            idx_next   = '0;
                            jdx_next   = fill_m1;
                            state_next = S_RV1;
                        end
                    end
                    MODE_DUMP:
                    begin
                        if (!empty)
                        begin
                            mem_ren    = 1'b1;
                            mem_raddr  = '0;
                            idx_next   = '0;
                            last_next  = (int'(fill_reg) > MAX_RES) ? AW'(MAX_RES - 1)
                                                                    : fill_m1;
                            state_next = S_DUMP;
                        end
                    end
                    default:
                    begin
                        status_next = ST_INVALID;
                    end
                endcase
            end

            S_MVHOLD:
            begin
                hold_next   = mem_rdata;
                fin_next    = tgt_a;
                last_next   = tgt_a;
                rd_act_next = 1'b1;
                wp_next     = 1'b0;
                priority if (cur_reg > tgt_a)
                begin
                    idx_next   = cur_reg - AW'(1);
                    up_next    = 1'b0;
                    state_next = S_SHIFT;
                end
                else if (cur_reg < tgt_a)
                begin
                    idx_next   = cur_reg + AW'(1);
                    up_next    = 1'b1;
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_SHIFT:
            begin
                // write of the previous read overlaps the next read
                mem_we    = wp_reg;
                mem_waddr = wa_reg;
                mem_wdata = mem_rdata;
                if (rd_act_reg)
                begin
                    mem_ren   = 1'b1;
                    mem_raddr = idx_reg;
                    wa_next   = up_reg ? idx_reg - AW'(1) : idx_reg + AW'(1);
                    wp_next   = 1'b1;
                    if (idx_reg == last_reg)
                        rd_act_next = 1'b0;
                    else
                        idx_next = up_reg ? idx_reg + AW'(1) : idx_reg - AW'(1);
                end
                else
                begin
                    wp_next    = 1'b0;
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                state_next = S_RESP;
                unique case (mode_reg)
                    MODE_INSERT:
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = fin_reg;
                        mem_wdata = data_reg;
                        fill_next = fill_reg + CW'(1);
                        cur_next  = fin_reg;
                    end
                    MODE_MOVE:
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = fin_reg;
                        mem_wdata = hold_reg;
                        cur_next  = fin_reg;
                    end
                    default:
                    begin
                        // delete: cursor wraps to front when it falls off
                        fill_next = fill_reg - CW'(1);
                        if (CW'(cur_reg) >= fill_reg - CW'(1))
                            cur_next = '0;
                    end
                endcase
            end

            S_RDWAIT:
            begin
                byte_next  = mem_rdata;
                state_next = S_RESP;
            end

            S_RV1:
            begin
                hold_next  = mem_rdata;
                mem_ren    = 1'b1;
                mem_raddr  = jdx_reg;
                state_next = S_RV2;
            end

            S_RV2:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = mem_rdata;
                state_next = S_RV3;
            end

            S_RV3:
            begin
                mem_we    = 1'b1;
                mem_waddr = jdx_reg;
                mem_wdata = hold_reg;
                if (CW'(idx_reg) + CW'(2) < CW'(jdx_reg))
                begin
                    idx_next   = idx_reg + AW'(1);
                    jdx_next   = jdx_reg - AW'(1);
                    mem_ren    = 1'b1;
                    mem_raddr  = idx_reg + AW'(1);
                    state_next = S_RV1;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            S_DUMP:
            begin
                if (res_free)
                begin
                    if (dump_end)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next  = idx_reg + AW'(1);
                        mem_ren   = 1'b1;
                        mem_raddr = idx_reg + AW'(1);
                    end
                end
            end

            S_RESP:
            begin
                if (res_free)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            cur_reg    <= '0;
            rd_act_reg <= 1'b0;
            wp_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            cur_reg    <= cur_next;
            rd_act_reg <= rd_act_next;
            wp_reg     <= wp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        data_reg   <= data_next;
        tgt_reg    <= tgt_next;
        status_reg <= status_next;
        byte_reg   <= byte_next;
        hold_reg   <= hold_next;
        idx_reg    <= idx_next;
        jdx_reg    <= jdx_next;
        last_reg   <= last_next;
        wa_reg     <= wa_next;
        fin_reg    <= fin_next;
        up_reg     <= up_next;
    end

endmodule

### dv/tb_cursor_list_buffer_unit.sv
// Self-checking testbench for cursor_list_buffer_unit: directed requests, then
// random command sequences checked against a behavioral list model.
// Depends on clb_pkg and the cursor_list_buffer_unit RTL.
`timescale 1ns / 100ps

module tb_cursor_list_buffer_unit;
    import clb_pkg::*;

    localparam int LIST_CAP     = 32;
    localparam int RAND_ITEMS   = 100;
    localparam int DRAIN_CYCLES = 60;       // well past the longest shift walk
    localparam int LIMIT_CYCLES = 1000000;  // dumps under long stalls dominate

    // Mode codes the block does not implement; they must be refused
    localparam logic [3:0] MODE_SPARE_LO = 4'd14;
    localparam logic [3:0] MODE_SPARE_HI = 4'd15;

    logic       clk             = 1'b0;
    logic       rst_n           = 1'b0;
    logic       in_valid        = 1'b0;
    logic [3:0] mode            = '0;
    logic [7:0] data_byte       = '0;
    logic [4:0] target_position = '0;
    logic       out_stall       = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [1:0] status;
    logic [7:0] out_byte;
    logic [5:0] entry_count;
    logic [5:0] cursor_pos;
    logic       is_empty;
    logic       last_item;

    cursor_list_buffer_unit #(
        .CAPACITY(LIST_CAP)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .data_byte      (data_byte),
        .target_position(target_position),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .out_byte       (out_byte),
        .entry_count    (entry_count),
        .cursor_pos     (cursor_pos),
        .is_empty       (is_empty),
        .last_item      (last_item)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // List model: contents, fill count and cursor (-1 when empty)
    // ------------------------------------------------------------------
    logic [7:0] list_bytes [0:LIST_CAP-1];
    int         list_len = 0;
    int         list_cur = -1;

    res_t pending_results[$];   // results still owed by the block, oldest first

    int error_count    = 0;
    int requests_done  = 0;
    int results_seen   = 0;
    int full_refusals  = 0;
    int cycle_count    = 0;
    bit quiet          = 1'b0;  // no gaps and no new stalls while set

    function automatic void push_result(logic [1:0] st, logic [7:0] val, bit last);
        res_t r;
        r.status      = st;
        r.out_byte    = val;
        r.entry_count = list_len[5:0];
        r.cursor_pos  = list_cur[5:0];  // -1 wraps to all ones
        r.is_empty    = (list_len == 0);
        r.last_item   = last;
        pending_results.push_back(r);
    endfunction

    // Applies one accepted request to the list model and queues its results
    function automatic void apply_list_command(logic [3:0] op, logic [7:0] val,
                                               logic [4:0] tg);
        logic [1:0] st;
        logic [7:0] rd;
        logic [7:0] held;
        int         pos;
        int         tgi;
        int         i;
        int         n;
        bit         cur_ok;
        st     = ST_OK;
        rd     = '0;
        tgi    = int'(tg);
        cur_ok = (list_cur >= 0) && (list_cur < list_len);
        case (op)
            MODE_INSERT:
            begin
                if (list_len >= LIST_CAP)
                begin
                    st = ST_FULL;
                    full_refusals++;
                end
                else
                begin
                    pos = list_cur + 1;
                    if (pos > list_len) pos = list_len;
                    for (i = list_len; i > pos; i--) list_bytes[i] = list_bytes[i-1];
                    list_bytes[pos] = val;
                    list_len++;
                    list_cur = pos;
                end
            end
            MODE_FRONT:  if (list_len == 0) st = ST_INVALID; else list_cur = 0;
            MODE_REAR:   if (list_len == 0) st = ST_INVALID; else list_cur = list_len - 1;
            MODE_NEXT:   if (cur_ok && list_cur + 1 < list_len) list_cur++;
                         else st = ST_INVALID;
            MODE_PREV:   if (cur_ok && list_cur > 0) list_cur--; else st = ST_INVALID;
            MODE_DELETE:
            begin
                if (!cur_ok)
                begin
                    st = ST_INVALID;
                end
                else
                begin
                    for (i = list_cur; i + 1 < list_len; i++) list_bytes[i] = list_bytes[i+1];
                    list_len--;
                    if (list_len == 0) list_cur = -1;
                    else if (list_cur >= list_len) list_cur = 0;  // fell off the end
                end
            end
            MODE_READ:    if (cur_ok) rd = list_bytes[list_cur]; else st = ST_INVALID;
            MODE_REPLACE: if (cur_ok) list_bytes[list_cur] = val; else st = ST_INVALID;
            MODE_MOVE:
            begin
                if (!cur_ok || tgi >= list_len)
                begin
                    st = ST_INVALID;
                end
                else
                begin
                    held = list_bytes[list_cur];
                    if (list_cur > tgi)
                        for (i = list_cur; i > tgi; i--) list_bytes[i] = list_bytes[i-1];
                    else
                        for (i = list_cur; i < tgi; i++) list_bytes[i] = list_bytes[i+1];
                    list_bytes[tgi] = held;
                    list_cur = tgi;
                end
            end
            MODE_COUNT, MODE_EMPTY: ;
            MODE_CLEAR:
            begin
                list_len = 0;
                list_cur = -1;
            end
            MODE_REVERSE:
            begin
                for (i = 0; i < list_len / 2; i++)
                begin
                    held = list_bytes[i];
                    list_bytes[i] = list_bytes[list_len-1-i];
                    list_bytes[list_len-1-i] = held;
                end
            end
            MODE_DUMP:
            begin
                if (list_len == 0)
                begin
                    push_result(ST_OK, 8'h00, 1'b1);
                end
                else
                begin
                    n = (list_len < MAX_RES) ? list_len : MAX_RES;
                    for (i = 0; i < n; i++) push_result(ST_OK, list_bytes[i], i + 1 == n);
                end
                return;
            end
            default: st = ST_INVALID;
        endcase
        push_result(st, rd, 1'b1);
    endfunction

    // Single-result record typed in by hand for the directed rows
    function automatic res_t fixed_result(logic [1:0] st, logic [7:0] val,
                                          logic [5:0] cnt, logic [5:0] cur);
        res_t r;
        r.status      = st;
        r.out_byte    = val;
        r.entry_count = cnt;
        r.cursor_pos  = cur;
        r.is_empty    = (cnt == 6'd0);
        r.last_item   = 1'b1;
        return r;
    endfunction

    // Mostly back-to-back, sometimes a few cycles, rarely a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // Request side: hold the payload until the block takes it
    // ------------------------------------------------------------------
    task automatic issue_request(input logic [3:0] op, input logic [7:0] val,
                                 input logic [4:0] tg, input bit known,
                                 input res_t fixed);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        mode            <= op;
        data_byte       <= val;
        target_position <= tg;
        do @(posedge clk); while (in_stall);
        // accepted at this edge: update the model now
        apply_list_command(op, val, tg);
        if (known)
        begin
            void'(pending_results.pop_back());
            pending_results.push_back(fixed);
        end
        requests_done++;
    endtask

    // Random command, weighted toward the list-changing ones
    function automatic logic [3:0] pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (list_len < 3 && r < 50) return MODE_INSERT;
        if (r < 28) return MODE_INSERT;
        if (r < 33) return MODE_FRONT;
        if (r < 38) return MODE_REAR;
        if (r < 45) return MODE_NEXT;
        if (r < 52) return MODE_PREV;
        if (r < 62) return MODE_DELETE;
        if (r < 68) return MODE_READ;
        if (r < 73) return MODE_REPLACE;
        if (r < 84) return MODE_MOVE;
        if (r < 86) return MODE_COUNT;
        if (r < 88) return MODE_CLEAR;
        if (r < 90) return MODE_EMPTY;
        if (r < 94) return MODE_REVERSE;
        if (r < 97) return MODE_DUMP;
        return (r == 97) ? MODE_SPARE_LO : MODE_SPARE_HI;
    endfunction

    // Move targets mostly land inside the list, the rest anywhere in range
    function automatic logic [4:0] pick_target();
        if (list_len > 0 && $urandom_range(0, 3) != 0)
            return 5'($urandom_range(0, list_len - 1));
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic logic [7:0] pick_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    typedef struct {
        logic [3:0] op;
        logic [7:0] val;
        logic [4:0] tg;
        bit         known;
        res_t       fixed;
    } plan_row_t;

    plan_row_t plan[$];

    function automatic void plan_add(logic [3:0] op, logic [7:0] val, logic [4:0] tg,
                                     bit known, res_t fixed);
        plan_row_t row;
        row.op    = op;
        row.val   = val;
        row.tg    = tg;
        row.known = known;
        row.fixed = fixed;
        plan.push_back(row);
    endfunction

    initial
    begin : stimulus
        res_t none;
        res_t empty_ok;
        res_t empty_bad;
        int   directed_count;
        int   rand_sent;
        int   fills;
        int   k;
        none      = '0;
        empty_ok  = fixed_result(ST_OK, 8'h00, 6'd0, 6'h3F);
        empty_bad = fixed_result(ST_INVALID, 8'h00, 6'd0, 6'h3F);
        rand_sent = 0;
        fills     = 0;

        // Empty list: everything that needs a cursor is refused
        plan_add(MODE_COUNT,    8'h00, 5'd0,  1'b1, empty_ok);
        plan_add(MODE_DUMP,     8'h00, 5'd0,  1'b1, empty_ok);   // single closing result
        plan_add(MODE_FRONT,    8'h00, 5'd0,  1'b1, empty_bad);
        plan_add(MODE_REAR,     8'h00, 5'd0,  1'b1, empty_bad);
        plan_add(MODE_NEXT,     8'h00, 5'd0,  1'b1, empty_bad);
        plan_add(MODE_PREV,     8'h00, 5'd0,  1'b1, empty_bad);
        plan_add(MODE_DELETE,   8'h00, 5'd0,  1'b1, empty_bad);
        plan_add(MODE_READ,     8'h00, 5'd0,  1'b1, empty_bad);
        plan_add(MODE_REPLACE,  8'hFF, 5'd0,  1'b1, empty_bad);
        plan_add(MODE_MOVE,     8'h00, 5'd0,  1'b1, empty_bad);
        plan_add(MODE_SPARE_LO, 8'h00, 5'd0,  1'b1, empty_bad);
        plan_add(MODE_SPARE_HI, 8'hFF, 5'd31, 1'b1, empty_bad);
        plan_add(MODE_EMPTY,    8'h00, 5'd0,  1'b1, empty_ok);
        // Three entries, byte extremes
        plan_add(MODE_INSERT,   8'h00, 5'd0,  1'b1, fixed_result(ST_OK, 8'h00, 6'd1, 6'd0));
        plan_add(MODE_INSERT,   8'hFF, 5'd0,  1'b1, fixed_result(ST_OK, 8'h00, 6'd2, 6'd1));
        plan_add(MODE_INSERT,   8'hA5, 5'd0,  1'b1, fixed_result(ST_OK, 8'h00, 6'd3, 6'd2));
        plan_add(MODE_READ,     8'h00, 5'd0,  1'b1, fixed_result(ST_OK, 8'hA5, 6'd3, 6'd2));
        plan_add(MODE_MOVE,     8'h00, 5'd31, 1'b1,
                 fixed_result(ST_INVALID, 8'h00, 6'd3, 6'd2));
        plan_add(MODE_MOVE,     8'h00, 5'd0,  1'b0, none);
        // Steps refused at both ends
        plan_add(MODE_REAR,     8'h00, 5'd0,  1'b0, none);
        plan_add(MODE_NEXT,     8'h00, 5'd0,  1'b1,
                 fixed_result(ST_INVALID, 8'h00, 6'd3, 6'd2));
        plan_add(MODE_FRONT,    8'h00, 5'd0,  1'b0, none);
        plan_add(MODE_PREV,     8'h00, 5'd0,  1'b1,
                 fixed_result(ST_INVALID, 8'h00, 6'd3, 6'd0));
        plan_add(MODE_REVERSE,  8'h00, 5'd0,  1'b0, none);
        plan_add(MODE_DUMP,     8'h00, 5'd0,  1'b0, none);
        plan_add(MODE_REPLACE,  8'h5A, 5'd0,  1'b0, none);
        // Delete at the tail: cursor wraps to the front
        plan_add(MODE_REAR,     8'h00, 5'd0,  1'b0, none);
        plan_add(MODE_DELETE,   8'h00, 5'd0,  1'b0, none);
        plan_add(MODE_CLEAR,    8'h00, 5'd0,  1'b1, empty_ok);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            issue_request(plan[i].op, plan[i].val, plan[i].tg, plan[i].known, plan[i].fixed);
        directed_count = plan.size();

        // Random part. Every fourth block of 25 runs without gaps or new stalls.
        while (rand_sent < RAND_ITEMS)
        begin
            quiet = ((rand_sent / 25) % 4 == 3);
            if ((fills == 0 && rand_sent >= 40) || $urandom_range(0, 59) == 0)
            begin
                // Fill to capacity, bump into the full refusal, then work at full
                while (list_len < LIST_CAP)
                begin
                    issue_request(MODE_INSERT, pick_byte(), pick_target(), 1'b0, none);
                    rand_sent++;
                end
                issue_request(MODE_INSERT, pick_byte(), 5'd0, 1'b0, none);
                issue_request(MODE_REVERSE, 8'h00, 5'd0, 1'b0, none);
                issue_request(MODE_FRONT, 8'h00, 5'd0, 1'b0, none);
                issue_request(MODE_MOVE, 8'h00, 5'd31, 1'b0, none);
                issue_request(MODE_DUMP, 8'h00, 5'd0, 1'b0, none);
                rand_sent += 5;
                fills++;
            end
            else
            begin
                k = $urandom_range(1, 8);
                repeat (k)
                begin
                    issue_request(pick_mode(), pick_byte(), pick_target(), 1'b0, none);
                    rand_sent++;
                end
            end
        end
        in_valid <= 1'b0;
        quiet = 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests (%0d directed, %0d list fills to capacity).",
                 requests_done, directed_count, fills);
        $display("%0d results compared, %0d inserts refused as full.",
                 results_seen, full_refusals);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stall, compare with the oldest pending result
    // ------------------------------------------------------------------
    int stall_left = 0;

    function automatic void check_field(string name, int expv, int actv);
        if (expv !== actv)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, expv, actv);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        res_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got status %0d byte %0d",
                         $realtime, status, out_byte);
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                check_field("status",      int'(exp_res.status),      int'(status));
                check_field("out_byte",    int'(exp_res.out_byte),    int'(out_byte));
                check_field("entry_count", int'(exp_res.entry_count), int'(entry_count));
                check_field("cursor_pos",  int'(exp_res.cursor_pos),  int'(cursor_pos));
                check_field("is_empty",    int'(exp_res.is_empty),    int'(is_empty));
                check_field("last_item",   int'(exp_res.last_item),   int'(last_item));
            end
        end
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
            end
            else if (quiet)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                stall_left = pick_gap();
                if (stall_left == 0)
                begin
                    out_stall <= 1'b0;
                    stall_left = $urandom_range(0, 4);
                end
                else
                begin
                    out_stall <= 1'b1;
                    stall_left--;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d results outstanding", $realtime,
                     pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

### filelist.f
hw/rtl/clb_pkg.sv
hw/rtl/clb_store.sv
hw/rtl/clb_seq.sv
hw/rtl/cursor_list_buffer_unit.sv
dv/tb_cursor_list_buffer_unit.sv
